// ===== sv/sprt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Split packet reassembly tracker package
// Shared constants, result codes and the structs passed between the
// tracker's register stage and its evaluation logic.
// ----------------------------------------------------------------------------
package sprt_pkg;

    localparam int MAX_PIECES   = 32;
    localparam int HEADER_BYTES = 12;
    localparam int BUFFER_BYTES = 262144;

    localparam int SPLIT_W = 15;
    localparam int NUM_W   = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
    localparam int REM_W   = $clog2(MAX_PIECES + 1);
    localparam int OFS_W   = NUM_W + SPLIT_W;
    localparam int SUM_W   = ((OFS_W > 16) ? OFS_W : 16) + 1;
    localparam int CMP_W   = (SUM_W > 25) ? SUM_W : 25;

    localparam logic [31:0] NO_SERIES = 32'hFFFF_FFFF;

    localparam logic REG_MIN_SPLIT = 1'b0;
    localparam logic REG_MAX_SPLIT = 1'b1;

    typedef enum logic [2:0] {
        ST_PENDING   = 3'd0,
        ST_COMPLETE  = 3'd1,
        ST_TOO_SHORT = 3'd2,
        ST_BAD_SPLIT = 3'd3,
        ST_BAD_ID    = 3'd4,
        ST_MISMATCH  = 3'd5,
        ST_TOO_LARGE = 3'd6
    } status_t;

    typedef struct packed {
        logic [31:0] seq;
        logic [15:0] pid;
        logic [15:0] split;
        logic [15:0] plen;
    } item_t;

    typedef struct packed {
        logic [31:0]      cur;
        logic [REM_W-1:0] rem;
        logic [15:0]      exp_split;
        logic [SUM_W-1:0] asm_size;
    } track_t;

    typedef struct packed {
        status_t     status;
        logic        dup;
        logic [22:0] offset;
        logic [15:0] copy_len;
        logic [22:0] total;
        logic        beyond;
    } result_t;

    typedef struct packed {
        track_t trk;
        logic   slot_we;
    } update_t;

endpackage

// ===== sv/sprt_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Split packet reassembly evaluation
// Checks one registered header against the configuration and the tracking
// state, and produces the result and the next tracking state.
// ----------------------------------------------------------------------------
module sprt_eval (
    input  sprt_pkg::item_t                 item,
    input  sprt_pkg::track_t                trk,
    input  logic [sprt_pkg::SPLIT_W-1:0]    min_split,
    input  logic [sprt_pkg::SPLIT_W-1:0]    max_split,
    input  logic [31:0]                     slot_seq,
    output sprt_pkg::result_t               res,
    output sprt_pkg::update_t               upd
);

    logic [7:0]                   number;
    logic [7:0]                   count;
    logic                         split_ok;
    logic                         id_ok;
    logic                         restart;
    logic                         seen;
    logic                         last_piece;
    logic [sprt_pkg::REM_W-1:0]   eff_rem;
    logic [sprt_pkg::REM_W-1:0]   rem_new;
    logic [sprt_pkg::SUM_W-1:0]   asm_new;
    logic [15:0]                  copy_len;
    logic [sprt_pkg::OFS_W-1:0]   ofs;
    logic [sprt_pkg::SUM_W-1:0]   end_pos;

    assign number   = item.pid[15:8];
    assign count    = item.pid[7:0];
    assign split_ok = !item.split[15]
                      && (item.split[14:0] >= min_split)
                      && (item.split[14:0] <= max_split);
    assign id_ok    = (number < 8'(sprt_pkg::MAX_PIECES))
                      && (count <= 8'(sprt_pkg::MAX_PIECES));
    assign restart  = (trk.cur == sprt_pkg::NO_SERIES) || (item.seq != trk.cur);
    assign seen     = (slot_seq == item.seq);
    assign copy_len = 16'(item.plen - 16'(sprt_pkg::HEADER_BYTES));
    assign ofs      = sprt_pkg::OFS_W'(number[sprt_pkg::NUM_W-1:0])
                      * sprt_pkg::OFS_W'(item.split[14:0]);
    assign end_pos  = sprt_pkg::SUM_W'(ofs) + sprt_pkg::SUM_W'(copy_len);

    // The last piece has number count - 1, so its end position is the total.
    assign last_piece = (count != 8'd0) && (number == count - 8'd1);
    assign eff_rem    = restart ? sprt_pkg::REM_W'(count) : trk.rem;
    assign rem_new    = (!seen && eff_rem != '0) ? eff_rem - 1'b1 : eff_rem;
    assign asm_new    = (!seen && last_piece) ? end_pos : trk.asm_size;

    always_comb
    begin
        res         = '0;
        res.status  = sprt_pkg::ST_PENDING;
        upd.trk     = trk;
        upd.slot_we = 1'b0;
        if (item.plen < 16'(sprt_pkg::HEADER_BYTES))
        begin
            res.status = sprt_pkg::ST_TOO_SHORT;
        end
        else if (!split_ok)
        begin
            res.status = sprt_pkg::ST_BAD_SPLIT;
        end
        else if (!id_ok)
        begin
            res.status = sprt_pkg::ST_BAD_ID;
        end
        else if (!restart && (trk.exp_split != item.split))
        begin
            res.status = sprt_pkg::ST_MISMATCH;
        end
        else
        begin
            res.dup      = seen;
            res.offset   = 23'(ofs);
            res.copy_len = copy_len;
            res.beyond   = sprt_pkg::CMP_W'(end_pos) > sprt_pkg::CMP_W'(sprt_pkg::BUFFER_BYTES);
            upd.slot_we  = !seen;
            upd.trk.rem      = rem_new;
            upd.trk.asm_size = asm_new;
            upd.trk.cur      = item.seq;
            if (restart)
            begin
                upd.trk.exp_split = item.split;
            end
            if (rem_new == '0)
            begin
                upd.trk.cur = sprt_pkg::NO_SERIES;
                res.total   = 23'(asm_new);
                if (sprt_pkg::CMP_W'(asm_new) > sprt_pkg::CMP_W'(sprt_pkg::BUFFER_BYTES))
                begin
                    res.status = sprt_pkg::ST_TOO_LARGE;
                end
                else
                begin
                    res.status = sprt_pkg::ST_COMPLETE;
                end
            end
        end
    end

endmodule

// ===== sv/split_packet_reassembly_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Split packet reassembly tracker
// Tracks the pieces of one split datagram series and reports status, write
// offset, copy length and the reassembled size for every header.
// Headers are registered in the input stage, results in the output register.
// Throughput: one header per cycle unless output stalls; the tracking state
// and per-slot sequence tags are read, checked and rewritten in the same cycle.
// Reset clears the handshake, restores the split-size window to 564..1248,
// closes the series and sets every slot tag to minus one.
// ----------------------------------------------------------------------------
module split_packet_reassembly_tracker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] sequence_number,
    input  logic [15:0]        packet_id,
    input  logic signed [15:0] split_size,
    input  logic [15:0]        packet_length,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic               duplicate,
    output logic [22:0]        write_offset,
    output logic [15:0]        copy_length,
    output logic [22:0]        total_size,
    output logic               write_beyond_buffer
);

    logic [sprt_pkg::SPLIT_W-1:0] min_split_reg;
    logic [sprt_pkg::SPLIT_W-1:0] max_split_reg;
    logic                         s1_valid_reg;
    sprt_pkg::item_t              s1_item_reg;
    logic                         out_valid_reg;
    sprt_pkg::result_t            res_reg;
    sprt_pkg::result_t            res_next;
    sprt_pkg::track_t             trk_reg;
    sprt_pkg::update_t            upd;
    logic [31:0]                  slot_reg [sprt_pkg::MAX_PIECES];
    logic [sprt_pkg::NUM_W-1:0]   slot_idx;
    logic                         cfg_write;
    logic                         in_accept;
    logic                         advance;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = paddr[2] ? 32'(max_split_reg) : 32'(min_split_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_split_reg <= sprt_pkg::SPLIT_W'(564);
            max_split_reg <= sprt_pkg::SPLIT_W'(1248);
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                sprt_pkg::REG_MIN_SPLIT: min_split_reg <= pwdata[sprt_pkg::SPLIT_W-1:0];
                sprt_pkg::REG_MAX_SPLIT: max_split_reg <= pwdata[sprt_pkg::SPLIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign slot_idx  = s1_item_reg.pid[8 +: sprt_pkg::NUM_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg.seq   <= sequence_number;
            s1_item_reg.pid   <= packet_id;
            s1_item_reg.split <= split_size;
            s1_item_reg.plen  <= packet_length;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trk_reg.cur       <= sprt_pkg::NO_SERIES;
            trk_reg.rem       <= '0;
            trk_reg.exp_split <= '0;
            trk_reg.asm_size  <= '0;
            for (int i = 0; i < sprt_pkg::MAX_PIECES; i++)
            begin
                slot_reg[i] <= sprt_pkg::NO_SERIES;
            end
        end
        else if (advance)
        begin
            trk_reg <= upd.trk;
            if (upd.slot_we)
            begin
                slot_reg[slot_idx] <= s1_item_reg.seq;
            end
        end
    end

    sprt_eval u_eval (
        .item      (s1_item_reg),
        .trk       (trk_reg),
        .min_split (min_split_reg),
        .max_split (max_split_reg),
        .slot_seq  (slot_reg[slot_idx]),
        .res       (res_next),
        .upd       (upd)
    );

    assign out_valid           = out_valid_reg;
    assign status              = res_reg.status;
    assign duplicate           = res_reg.dup;
    assign write_offset        = res_reg.offset;
    assign copy_length         = res_reg.copy_len;
    assign total_size          = res_reg.total;
    assign write_beyond_buffer = res_reg.beyond;

endmodule
